[rtl/mwo_pkg.sv]
package mwo_pkg;

  localparam int unsigned SINE_ROM_BITS_DEF = 10;
  localparam int unsigned OUTPUT_BITS_DEF   = 16;

  // shared multiplier: signed operands wide enough for 32-bit unsigned values
  localparam int unsigned MUL_W = 33;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd2;

  localparam logic [2:0] WAVE_SINE   = 3'd0;
  localparam logic [2:0] WAVE_SQUARE = 3'd1;
  localparam logic [2:0] WAVE_TRI    = 3'd2;
  localparam logic [2:0] WAVE_FALL   = 3'd3;
  localparam logic [2:0] WAVE_RISE   = 3'd4;
  localparam logic [2:0] WAVE_NOISE  = 3'd5;

  localparam logic [15:0] GAIN_RESET = 16'd16384;

  localparam logic [31:0] LFSR_SEED = 32'hACE1_2468;
  localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

  // sin(pi/2 x) odd polynomial magnitudes, Q2.30
  localparam logic [31:0] SC1  = 32'd1686629713;
  localparam logic [31:0] SC3  = 32'd693598669;
  localparam logic [31:0] SC5  = 32'd85569308;
  localparam logic [31:0] SC7  = 32'd5026995;
  localparam logic [31:0] SC9  = 32'd172272;
  localparam logic [31:0] SC11 = 32'd3864;

  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_LAST = 3'd4;

  // coefficient subtracted at each horner step, highest order first
  function automatic logic [31:0] horner_coef(logic [STEP_W-1:0] step);
    logic [31:0] c;
    case (step)
      3'd0:    c = SC9;
      3'd1:    c = SC7;
      3'd2:    c = SC5;
      3'd3:    c = SC3;
      default: c = SC1;
    endcase
    return c;
  endfunction

endpackage

[rtl/mwo_if.sv]
interface mwo_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_index;

  modport source(output valid, output sample_index, input ready);
  modport sink(input valid, input sample_index, output ready);
endinterface

interface mwo_out_if #(
  parameter int unsigned OutBits = mwo_pkg::OUTPUT_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic signed [OutBits-1:0] sample_out;

  modport source(output valid, output sample_out, input ready);
  modport sink(input valid, input sample_out, output ready);
endinterface

interface mwo_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mwo_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                    data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

[rtl/multiwave_oscillator.sv]
// sine and square step through phase, x2, horner, sin, gain and rnd; others skip x2 to sin
// a new sample index is taken only in idle, once the last result is loaded for output
// one registered 33x33 multiplier forms the phase product,
// the seven products of the sine polynomial and the gain product in turn
// reset (async, active low): config registers to defaults, noise lfsr to its seed, sequencer idle
module multiwave_oscillator #(
  parameter int unsigned SINE_ROM_BITS = mwo_pkg::SINE_ROM_BITS_DEF,
  parameter int unsigned OUTPUT_BITS   = mwo_pkg::OUTPUT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mwo_in_if.sink    smp_i,
  mwo_out_if.source smp_o,
  mwo_cfg_if.sink   cfg_i
);
  import mwo_pkg::*;

  localparam int unsigned ProdW    = 2 * MUL_W;
  localparam int unsigned RndShift = 30 - OUTPUT_BITS;
  localparam int unsigned XPad     = 30 - SINE_ROM_BITS;

  localparam logic signed [ProdW-1:0] RndHalf = ProdW'(1) << (RndShift - 1);
  localparam logic signed [ProdW-1:0] OutMax  = (ProdW'(1) << (OUTPUT_BITS - 1)) - ProdW'(1);
  localparam logic signed [ProdW-1:0] OutMin  = -(ProdW'(1) << (OUTPUT_BITS - 1));
  localparam logic [SINE_ROM_BITS:0]  QuarterTurn = (SINE_ROM_BITS + 1)'(1) << SINE_ROM_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PHASE = 3'd1;
  localparam logic [2:0] S_X2    = 3'd2;
  localparam logic [2:0] S_HORN  = 3'd3;
  localparam logic [2:0] S_SIN   = 3'd4;
  localparam logic [2:0] S_GAIN  = 3'd5;
  localparam logic [2:0] S_RND   = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [2:0]  wave_q;
  logic [31:0] inc_q;
  logic [15:0] gain_q;
  logic [31:0] lfsr_q, lfsr_d;
  logic [30:0] x_q, x_d;
  logic [30:0] x2_q, x2_d;
  logic [1:0]  quad_q, quad_d;
  logic signed [16:0] pre_q, pre_d;
  logic        out_valid_q, out_valid_d;
  logic signed [OUTPUT_BITS-1:0] out_data_q, out_data_d;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [ProdW-1:0] prod;

  logic        in_acc, out_load, sine_path;
  logic [31:0] phase;
  logic [SINE_ROM_BITS-1:0] rom_idx;
  logic [SINE_ROM_BITS:0]   rom_k;
  logic [30:0] x_new;
  logic [16:0] tri_u;
  logic signed [16:0] pre_other;
  logic [31:0] horn_p;
  logic [32:0] sin_s;
  logic [32:0] sin_rs;
  logic [14:0] sin_v;
  logic signed [16:0] pre_sine;
  logic signed [ProdW-1:0] rnd_sum, rnd_val;
  logic signed [OUTPUT_BITS-1:0] sat_val;

  mwo_mul #(.MulW(MUL_W)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= WAVE_SINE;
      inc_q  <= '0;
      gain_q <= GAIN_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_WAVE: wave_q <= cfg_i.data[2:0];
        CFG_INC:  inc_q  <= cfg_i.data;
        CFG_GAIN: gain_q <= cfg_i.data[15:0];
        default:  ;
      endcase
    end
  end

  assign smp_i.ready      = (state_q == S_IDLE);
  assign in_acc           = smp_i.valid && smp_i.ready;
  assign smp_o.valid      = out_valid_q;
  assign smp_o.sample_out = out_data_q;

  // phase and waveforms that need no polynomial
  assign phase   = prod[31:0];
  assign rom_idx = phase[29 -: SINE_ROM_BITS];
  assign rom_k   = phase[30] ? (QuarterTurn - {1'b0, rom_idx}) : {1'b0, rom_idx};
  assign x_new   = 31'(rom_k) << XPad;
  assign tri_u   = phase[31:15];

  assign sine_path = !((wave_q == WAVE_TRI) || (wave_q == WAVE_FALL) ||
                       (wave_q == WAVE_RISE) || (wave_q == WAVE_NOISE));

  always_comb begin
    case (wave_q)
      WAVE_TRI: begin
        if (tri_u < 17'd32768) begin
          pre_other = $signed(tri_u);
        end else if (tri_u < 17'd98304) begin
          pre_other = $signed(17'h10000 - tri_u);
        end else begin
          pre_other = $signed(tri_u);
        end
      end
      WAVE_FALL:  pre_other = $signed(17'd32768 - {1'b0, phase[31:16]});
      WAVE_RISE:  pre_other = $signed({1'b0, phase[31:16]} - 17'd32768);
      default:    pre_other = $signed({1'b0, lfsr_q[31:16]} - 17'd32768);
    endcase
  end

  // polynomial step and sine finish
  assign horn_p = horner_coef(step_q) - prod[61:30];
  assign sin_s  = prod[62:30];
  assign sin_rs = (sin_s + 33'd16384) >> 15;
  assign sin_v  = (sin_rs > 33'd32767) ? 15'h7fff : sin_rs[14:0];

  always_comb begin
    if (quad_q[1]) begin
      pre_sine = -$signed({2'b00, sin_v});
    end else begin
      pre_sine = $signed({2'b00, sin_v});
    end
  end

  // gain rounding, half toward plus infinity, then saturation
  assign rnd_sum = prod + RndHalf;
  assign rnd_val = rnd_sum >>> RndShift;

  always_comb begin
    if (rnd_val > OutMax) begin
      sat_val = OutMax[OUTPUT_BITS-1:0];
    end else if (rnd_val < OutMin) begin
      sat_val = OutMin[OUTPUT_BITS-1:0];
    end else begin
      sat_val = rnd_val[OUTPUT_BITS-1:0];
    end
  end

  assign out_load = (state_q == S_RND) && (!out_valid_q || smp_o.ready);

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    x_d      = x_q;
    x2_d     = x2_q;
    quad_d   = quad_q;
    pre_d    = pre_q;
    lfsr_d   = lfsr_q;
    mul_a    = MUL_W'(pre_q);
    mul_b    = $signed(MUL_W'(gain_q));

    unique case (state_q)
      S_IDLE: begin
        mul_a = $signed(MUL_W'(smp_i.sample_index));
        mul_b = $signed(MUL_W'(inc_q));
        if (in_acc) begin
          state_d = S_PHASE;
          if (wave_q == WAVE_NOISE) begin
            lfsr_d = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_MASK) : (lfsr_q >> 1);
          end
        end
      end
      S_PHASE: begin
        mul_a = $signed(MUL_W'(x_new));
        mul_b = $signed(MUL_W'(x_new));
        if (sine_path) begin
          x_d     = x_new;
          quad_d  = phase[31:30];
          state_d = S_X2;
        end else begin
          pre_d   = pre_other;
          state_d = S_GAIN;
        end
      end
      S_X2: begin
        x2_d    = prod[60:30];
        mul_a   = $signed(MUL_W'(SC11));
        mul_b   = $signed(MUL_W'(prod[60:30]));
        step_d  = '0;
        state_d = S_HORN;
      end
      S_HORN: begin
        mul_a = $signed(MUL_W'(horn_p));
        if (step_q == STEP_LAST) begin
          mul_b   = $signed(MUL_W'(x_q));
          state_d = S_SIN;
        end else begin
          mul_b   = $signed(MUL_W'(x2_q));
          step_d  = step_q + 1'b1;
        end
      end
      S_SIN: begin
        if (wave_q == WAVE_SQUARE) begin
          pre_d = (pre_sine <= 17'sd0) ? 17'sd32768 : -17'sd32768;
        end else begin
          pre_d = pre_sine;
        end
        state_d = S_GAIN;
      end
      S_GAIN: begin
        state_d = S_RND;
      end
      S_RND: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (smp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = sat_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      lfsr_q      <= LFSR_SEED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      lfsr_q      <= lfsr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    x2_q       <= x2_d;
    quad_q     <= quad_d;
    pre_q      <= pre_d;
    out_data_q <= out_data_d;
  end

`ifndef ASSERT_OFF
  a_acc_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_PHASE))
    else $error("accepted transaction did not start the sequencer");

  a_lfsr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != 32'd0)
    else $error("noise lfsr reached the all-zero state");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HORN) |-> (step_q <= STEP_LAST))
    else $error("horner step out of range");

  a_load_from_rnd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == S_RND))
    else $error("result appeared without a rounding step");

  a_lfsr_only_noise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lfsr_q != $past(lfsr_q)) |-> ($past(in_acc) && ($past(wave_q) == WAVE_NOISE)))
    else $error("noise lfsr advanced outside a noise transaction");
`endif

endmodule

[rtl/mwo_mul.sv]
module mwo_mul #(
  parameter int unsigned MulW = mwo_pkg::MUL_W
) (
  input  logic                     clk_i,
  input  logic signed [MulW-1:0]   a_i,
  input  logic signed [MulW-1:0]   b_i,
  output logic signed [2*MulW-1:0] p_o
);

  logic signed [2*MulW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import mwo_pkg::*;

  localparam int unsigned ROM_BITS = SINE_ROM_BITS_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int TARGET_ITEMS = 1650;
  localparam int TAIL_CYCLES = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // quarter-wave polynomial magnitudes, Q2.30, highest order last
  localparam longint unsigned POLY_C1 = 64'd1686629713;
  localparam longint unsigned POLY_C3 = 64'd693598669;
  localparam longint unsigned POLY_C5 = 64'd85569308;
  localparam longint unsigned POLY_C7 = 64'd5026995;
  localparam longint unsigned POLY_C9 = 64'd172272;
  localparam longint unsigned POLY_C11 = 64'd3864;

  localparam logic [31:0] NOISE_SEED = 32'hACE1_2468;
  localparam logic [31:0] NOISE_TAPS = 32'h8020_0003;
  localparam logic [15:0] UNITY_GAIN = 16'd16384;

  logic clk = 1'b0;
  logic rst_n;

  mwo_in_if  smp_in ();
  mwo_out_if smp_out ();
  mwo_cfg_if cfg ();

  multiwave_oscillator dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .smp_i (smp_in),
    .smp_o (smp_out),
    .cfg_i (cfg)
  );

  // oscillator settings and noise register as the predictor sees them
  logic [2:0]  wave_sel;
  logic [31:0] phase_inc;
  logic [15:0] amp_gain;
  logic [31:0] noise_state;

  logic signed [15:0] expected_samples[$];

  int err_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int setting_count = 0;
  int idle_cycles = 0;
  int wave_hits[8];
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int quarter_sine(int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    x = 64'(k);
    x = x << (30 - ROM_BITS);
    x2 = (x * x) >> 30;
    p = POLY_C11;
    p = POLY_C9 - ((p * x2) >> 30);
    p = POLY_C7 - ((p * x2) >> 30);
    p = POLY_C5 - ((p * x2) >> 30);
    p = POLY_C3 - ((p * x2) >> 30);
    p = POLY_C1 - ((p * x2) >> 30);
    p = (p * x) >> 30;
    p = (p + 64'd16384) >> 15;
    if (p > 64'd32767) p = 64'd32767;
    return int'(p);
  endfunction

  function automatic int sine_at_phase(logic [31:0] phase);
    int unsigned k;
    int v;
    k = 32'(phase[29 -: ROM_BITS]);
    // odd quadrants run the table backwards, upper half is negated
    if (phase[30]) v = quarter_sine((1 << ROM_BITS) - k);
    else v = quarter_sine(k);
    return phase[31] ? -v : v;
  endfunction

  function automatic logic signed [15:0] predict_sample(logic [31:0] sample_index);
    logic [31:0] phase;
    int pre;
    int u;
    longint prod;
    longint scaled;
    phase = sample_index * phase_inc;
    case (wave_sel)
      WAVE_SQUARE: pre = (sine_at_phase(phase) <= 0) ? 32768 : -32768;
      WAVE_TRI: begin
        u = phase >> 15;
        if (u < 32768) pre = u;
        else if (u < 98304) pre = 65536 - u;
        else pre = u - 131072;
      end
      WAVE_FALL: pre = 32768 - int'(phase[31:16]);
      WAVE_RISE: pre = int'(phase[31:16]) - 32768;
      WAVE_NOISE: begin
        if (noise_state[0]) noise_state = (noise_state >> 1) ^ NOISE_TAPS;
        else noise_state = noise_state >> 1;
        pre = int'(noise_state[31:16]) - 32768;
      end
      default: pre = sine_at_phase(phase);
    endcase
    prod = longint'(pre) * longint'(amp_gain);
    // Q.29 down to Q.15, round half up, then clamp
    scaled = (prod + 64'sd8192) >>> 14;
    if (scaled > 32767) scaled = 32767;
    else if (scaled < -32768) scaled = -32768;
    return scaled[15:0];
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 25;
      default: return 100;
    endcase
  endfunction

  task automatic send_sample_index(input logic [31:0] sample_index);
    int gap;
    gap = ($urandom_range(0, 99) < src_idle_pct) ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap != 0) begin
      smp_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    smp_in.valid <= 1'b1;
    smp_in.sample_index <= sample_index;
    do @(posedge clk); while (smp_in.ready !== 1'b1);
    expected_samples.push_back(predict_sample(sample_index));
    wave_hits[wave_sel]++;
    sent_count++;
  endtask

  task automatic drain_samples();
    @(negedge clk);
    smp_in.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] reg_index, input logic [31:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= reg_index;
    cfg.data <= value;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    case (reg_index)
      CFG_WAVE: wave_sel = value[2:0];
      CFG_INC:  phase_inc = value;
      CFG_GAIN: amp_gain = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // settings straight out of reset: sine at zero increment
  task automatic test_reset_state();
    send_sample_index(32'h0000_0000);
    send_sample_index(32'hFFFF_FFFF);
    drain_samples();
  endtask

  task automatic test_sine_quadrants();
    logic [31:0] pts[5];
    pts = '{32'd0, 32'd1023, 32'd1024, 32'd2048, 32'd3072};
    src_idle_pct = 100;
    snk_idle_pct = 0;
    // one table step per index
    write_register(CFG_INC, 32'h0010_0000);
    write_register(CFG_WAVE, {29'd0, WAVE_SINE});
    foreach (pts[i]) send_sample_index(pts[i]);
    drain_samples();
  endtask

  task automatic test_square_sign();
    src_idle_pct = 0;
    snk_idle_pct = 100;
    write_register(CFG_WAVE, {29'd0, WAVE_SQUARE});
    send_sample_index(32'd1);
    send_sample_index(32'd2048);
    send_sample_index(32'd3000);
    drain_samples();
  endtask

  task automatic test_phase_shapes();
    src_idle_pct = 25;
    snk_idle_pct = 25;
    write_register(CFG_INC, 32'd1);
    write_register(CFG_WAVE, {29'd0, WAVE_TRI});
    send_sample_index(32'h3FFF_FFFF);
    send_sample_index(32'h4000_0000);
    send_sample_index(32'hC000_0000);
    drain_samples();
    write_register(CFG_WAVE, {29'd0, WAVE_FALL});
    send_sample_index(32'h0000_0000);
    drain_samples();
    write_register(CFG_WAVE, {29'd0, WAVE_RISE});
    send_sample_index(32'h0000_0000);
    send_sample_index(32'hFFFF_FFFF);
    drain_samples();
  endtask

  task automatic test_gain_rounding();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    // half gain on +-1 lands exactly on the rounding tie
    write_register(CFG_GAIN, 32'd8192);
    send_sample_index(32'h8001_0000);
    send_sample_index(32'h7FFF_0000);
    drain_samples();
    write_register(CFG_GAIN, 32'hFFFF_FFFF);
    send_sample_index(32'h0000_0000);
    send_sample_index(32'hFFFF_FFFF);
    drain_samples();
    write_register(CFG_GAIN, 32'd0);
    send_sample_index(32'h0000_0000);
    drain_samples();
    write_register(CFG_GAIN, {16'd0, UNITY_GAIN});
  endtask

  // the noise register must hold still while another waveform runs
  task automatic test_noise_sequence();
    src_idle_pct = 100;
    snk_idle_pct = 100;
    write_register(CFG_WAVE, {29'd0, WAVE_NOISE});
    send_sample_index(32'd0);
    send_sample_index(32'd0);
    drain_samples();
    write_register(CFG_WAVE, {29'd0, WAVE_SINE});
    send_sample_index(32'h1234_5678);
    drain_samples();
    write_register(CFG_WAVE, {29'd0, WAVE_NOISE});
    send_sample_index(32'hFFFF_FFFF);
    drain_samples();
  endtask

  task automatic test_unused_codes();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    // selector codes past noise fall back to sine; upper data bits are dropped
    write_register(CFG_WAVE, 32'hFFFF_FFFE);
    send_sample_index(32'h0100_0000);
    drain_samples();
    write_register(CFG_SPARE, $urandom());
    write_register(CFG_WAVE, 32'h0000_0007);
    send_sample_index(32'h0100_0000);
    drain_samples();
  endtask

  task automatic test_random_phases();
    logic [31:0] word;
    logic [31:0] idx;
    int n;
    while (sent_count < TARGET_ITEMS) begin
      setting_count++;
      word = $urandom();
      word[2:0] = 3'($urandom_range(0, 7));
      write_register(CFG_WAVE, word);
      case ($urandom_range(0, 6))
        0: word = 32'd0;
        1: word = 32'hFFFF_FFFF;
        2: word = $urandom_range(1, 65535);
        3: word = 32'd1 << $urandom_range(0, 31);
        default: word = $urandom();
      endcase
      write_register(CFG_INC, word);
      word = $urandom();
      case ($urandom_range(0, 5))
        0: word[15:0] = 16'd0;
        1: word[15:0] = 16'hFFFF;
        2: word[15:0] = UNITY_GAIN;
        default: ;
      endcase
      write_register(CFG_GAIN, word);
      src_idle_pct = pick_idle_pct();
      snk_idle_pct = pick_idle_pct();
      n = $urandom_range(10, 60);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: idx = $urandom_range(0, 4095);
          1: idx = 32'hFFFF_FFFF - $urandom_range(0, 4095);
          default: idx = $urandom();
        endcase
        send_sample_index(idx);
      end
      drain_samples();
    end
  endtask

  initial begin : result_sink
    logic signed [15:0] want;
    int stall;
    smp_out.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = ($urandom_range(0, 99) < snk_idle_pct) ? $urandom_range(0, 19) : 0;
      @(negedge clk);
      if (stall != 0) begin
        smp_out.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      smp_out.ready <= 1'b1;
      do @(posedge clk); while (smp_out.valid !== 1'b1);
      checked_count++;
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample, expected none, actual %0d", $time,
                 smp_out.sample_out);
        err_count++;
      end else begin
        want = expected_samples.pop_front();
        if (smp_out.sample_out !== want) begin
          $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time, want,
                   smp_out.sample_out);
          err_count++;
        end
      end
    end
  end

  // cycles without any transaction on any channel
  always @(posedge clk) begin
    if ((smp_in.valid && smp_in.ready) || (smp_out.valid && smp_out.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    smp_in.valid = 1'b0;
    smp_in.sample_index = '0;
    cfg.valid = 1'b0;
    cfg.index = CFG_WAVE;
    cfg.data = '0;
    wave_sel = WAVE_SINE;
    phase_inc = '0;
    amp_gain = UNITY_GAIN;
    noise_state = NOISE_SEED;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_sine_quadrants();
    test_square_sign();
    test_phase_shapes();
    test_gain_rounding();
    test_noise_sequence();
    test_unused_codes();
    test_random_phases();

    drain_samples();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d sample indices, checked %0d samples, %0d random oscillator settings",
             sent_count, checked_count, setting_count);
    $display("samples per selector code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             wave_hits[0], wave_hits[1], wave_hits[2], wave_hits[3],
             wave_hits[4], wave_hits[5], wave_hits[6], wave_hits[7]);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
